// ===== sv/positional_ordered_list_unit_assert.svh =====
// assertion macros for the positional ordered list unit
`ifndef POSITIONAL_ORDERED_LIST_UNIT_ASSERT_SVH
`define POSITIONAL_ORDERED_LIST_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, checked out of reset
`define POLU_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication, checked out of reset
`define POLU_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define POLU_ASSERT_IMP(name, ante, cons, msg)
`define POLU_ASSERT_NXT(name, ante, cons, msg)
`endif
`endif

// ===== sv/polu_pkg.sv =====
// shared types and codes of the positional ordered list unit
package polu_pkg;

	// request action codes
	localparam logic [2:0] ACT_INSERT = 3'd0;
	localparam logic [2:0] ACT_DELETE = 3'd1;
	localparam logic [2:0] ACT_GET    = 3'd2;
	localparam logic [2:0] ACT_LOCATE = 3'd3;
	localparam logic [2:0] ACT_CLEAR  = 3'd4;

	localparam int IN_W  = 24;
	localparam int OUT_W = 32;

	// operation broadcast to every cell
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_INS,
		CELL_DEL,
		CELL_GET,
		CELL_LOC
	} cell_op_t;

	typedef struct packed {
		cell_op_t   op;
		logic [7:0] value;
	} cell_ctrl_t;

	// word passed down the cell chain toward cell zero
	typedef struct packed {
		logic       hit;
		logic [7:0] data;
	} chain_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	// result word, lowest field last
	typedef struct packed {
		logic       empty_res;
		logic [7:0] count;
		logic [7:0] found_position;
		logic [7:0] read_value;
		logic       status;
	} result_t;

endpackage

// ===== sv/positional_ordered_list_unit.sv =====
// positional ordered list unit: control, count and a chain of storage cells
// insert, delete, clear and bad requests: result registered straight from the decode at accept
// get and locate: the answer walks the cell chain, then is registered once the result register is free
// one request in flight; the next is taken once the result register is free
// async reset clears the count, the state and the result valid; slots are not cleared
`include "positional_ordered_list_unit_assert.svh"
module positional_ordered_list_unit #(
	parameter int CAPACITY = 128
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// action[2:0], position[10:3], value[18:11], zero fill
	input  logic [polu_pkg::IN_W-1:0] s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// status[0], read_value[8:1], found_position[16:9], count[24:17], empty_res[25], zero fill
	output logic [polu_pkg::OUT_W-1:0] m_tdata
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = ((CW > 8) ? CW : 8) + 1;
	localparam logic [XW-1:0] CAP_X = XW'(CAPACITY);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
	localparam int RW = $bits(polu_pkg::result_t);

	polu_pkg::state_t     state_q, state_d;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        scan_cnt_q;
	polu_pkg::cell_op_t   op_q;
	logic [XW-1:0]        key_q;
	logic [7:0]           val_q;
	logic                 out_valid_q;
	polu_pkg::result_t    res_q;

	logic [2:0]           act;
	logic [7:0]           pos;
	logic [7:0]           val;
	logic [XW-1:0]        pos_x;
	logic [XW-1:0]        cnt_x;
	logic                 ins_ok;
	logic                 rng_ok;
	logic                 imm_status;
	logic                 need_scan;
	polu_pkg::cell_op_t   dec_op;
	polu_pkg::cell_op_t   scan_op;
	logic [XW-1:0]        cnt_new;
	logic                 free;
	logic                 accept;
	logic                 scan_done;
	logic                 load_imm;
	logic                 load_scan;
	polu_pkg::cell_ctrl_t ctrl;
	logic [XW-1:0]        key;

	logic [7:0]           slot_w  [CAPACITY];
	polu_pkg::chain_t     chain_w [CAPACITY+1];

	assign act   = s_tdata[2:0];
	assign pos   = s_tdata[10:3];
	assign val   = s_tdata[18:11];
	assign pos_x = {{(XW-8){1'b0}}, pos};
	assign cnt_x = {{(XW-CW){1'b0}}, count_q};

	// position range checks
	assign ins_ok = (pos != 8'd0) && (pos_x <= cnt_x + XW'(1)) && (cnt_x < CAP_X);
	assign rng_ok = (pos != 8'd0) && (pos_x <= cnt_x);

	// request decode
	always_comb begin
		imm_status = 1'b0;
		need_scan  = 1'b0;
		dec_op     = polu_pkg::CELL_HOLD;
		scan_op    = polu_pkg::CELL_HOLD;
		cnt_new    = cnt_x;
		unique case (act)
			polu_pkg::ACT_INSERT: begin
				imm_status = !ins_ok;
				if (ins_ok) begin
					dec_op  = polu_pkg::CELL_INS;
					cnt_new = cnt_x + XW'(1);
				end
			end
			polu_pkg::ACT_DELETE: begin
				imm_status = !rng_ok;
				if (rng_ok) begin
					dec_op  = polu_pkg::CELL_DEL;
					cnt_new = cnt_x - XW'(1);
				end
			end
			polu_pkg::ACT_GET: begin
				imm_status = !rng_ok;
				need_scan  = rng_ok;
				scan_op    = polu_pkg::CELL_GET;
			end
			polu_pkg::ACT_LOCATE: begin
				need_scan = 1'b1;
				scan_op   = polu_pkg::CELL_LOC;
			end
			polu_pkg::ACT_CLEAR: cnt_new = '0;
			default: imm_status = 1'b1;
		endcase
	end

	// state machine: next state and handshake
	always_comb begin
		free      = !out_valid_q || m_tready;
		s_tready  = (state_q == polu_pkg::ST_IDLE) && free;
		accept    = s_tvalid && s_tready;
		scan_done = (scan_cnt_q == CAP_C);
		load_imm  = 1'b0;
		load_scan = 1'b0;
		state_d   = state_q;
		unique case (state_q)
			polu_pkg::ST_IDLE: begin
				if (accept) begin
					if (need_scan) begin
						state_d = polu_pkg::ST_SCAN;
					end else begin
						load_imm = 1'b1;
					end
				end
			end
			polu_pkg::ST_SCAN: begin
				if (scan_done && free) begin
					load_scan = 1'b1;
					state_d   = polu_pkg::ST_IDLE;
				end
			end
			default: state_d = polu_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= polu_pkg::ST_IDLE;
			count_q    <= '0;
			scan_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				count_q    <= cnt_new[CW-1:0];
				scan_cnt_q <= '0;
			end else if (state_q == polu_pkg::ST_SCAN && !scan_done) begin
				scan_cnt_q <= scan_cnt_q + CW'(1);
			end
		end
	end

	// scan request held for the cells
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= scan_op;
			key_q <= pos_x - XW'(1);
			val_q <= val;
		end
	end

	// broadcast to the cells
	always_comb begin
		if (accept) begin
			ctrl.op    = dec_op;
			ctrl.value = val;
			key        = pos_x - XW'(1);
		end else begin
			ctrl.op    = (state_q == polu_pkg::ST_SCAN) ? op_q : polu_pkg::CELL_HOLD;
			ctrl.value = val_q;
			key        = key_q;
		end
	end

	// cell row; the search word enters empty at the top end
	assign chain_w[CAPACITY] = '{hit: 1'b0, data: 8'h00};

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		polu_cell #(
			.XW (XW)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.key       (key),
			.cnt       (cnt_x),
			.idx       (XW'(i)),
			.left      ((i == 0) ? 8'h00 : slot_w[(i == 0) ? 0 : i-1]),
			.right     ((i == CAPACITY-1) ? 8'h00 : slot_w[(i == CAPACITY-1) ? i : i+1]),
			.chain_in  (chain_w[i+1]),
			.slot      (slot_w[i]),
			.chain_out (chain_w[i])
		);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_imm || load_scan) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_imm) begin
			res_q.status         <= imm_status;
			res_q.read_value     <= 8'h00;
			res_q.found_position <= 8'h00;
			res_q.count          <= cnt_new[7:0];
			res_q.empty_res      <= (cnt_new == '0);
		end else if (load_scan) begin
			res_q.status         <= 1'b0;
			res_q.read_value     <= (op_q == polu_pkg::CELL_GET) ? chain_w[0].data : 8'h00;
			res_q.found_position <= (op_q == polu_pkg::CELL_LOC && chain_w[0].hit) ?
				chain_w[0].data : 8'h00;
			res_q.count          <= cnt_x[7:0];
			res_q.empty_res      <= (count_q == '0);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(polu_pkg::OUT_W-RW){1'b0}}, res_q};

	// checks
	`POLU_ASSERT_IMP(a_count_cap, 1'b1, count_q <= CAP_C, "count above capacity")
	`POLU_ASSERT_NXT(a_scan_start, accept && need_scan,
		state_q == polu_pkg::ST_SCAN && scan_cnt_q == '0, "scan did not start")
	`POLU_ASSERT_NXT(a_scan_count, state_q == polu_pkg::ST_SCAN, $stable(count_q),
		"count moved during scan")

endmodule

// ===== sv/polu_cell.sv =====
// one storage cell of the list: holds a slot and one stage of the search chain
module polu_cell #(
	parameter int XW = 9
) (
	input  logic                 clk,
	input  polu_pkg::cell_ctrl_t ctrl,
	input  logic [XW-1:0]        key,
	input  logic [XW-1:0]        cnt,
	input  logic [XW-1:0]        idx,
	input  logic [7:0]           left,
	input  logic [7:0]           right,
	input  polu_pkg::chain_t     chain_in,
	output logic [7:0]           slot,
	output polu_pkg::chain_t     chain_out
);

	logic [7:0]       slot_q;
	logic [7:0]       slot_d;
	logic             hit;
	polu_pkg::chain_t chain_q;
	polu_pkg::chain_t chain_d;
	logic [XW-1:0]    idx_p1;

	assign idx_p1 = idx + XW'(1);

	// local shift and compare
	always_comb begin
		slot_d = slot_q;
		hit    = 1'b0;
		unique case (ctrl.op)
			polu_pkg::CELL_INS: begin
				if (idx == key) begin
					slot_d = ctrl.value;
				end else if (idx > key && idx <= cnt) begin
					slot_d = left;
				end
			end
			polu_pkg::CELL_DEL: begin
				if (idx >= key && idx_p1 < cnt) begin
					slot_d = right;
				end
			end
			polu_pkg::CELL_GET: hit = (idx == key);
			polu_pkg::CELL_LOC: hit = (idx < cnt) && (slot_q == ctrl.value);
			default: ;
		endcase
	end

	// the lowest hit wins as the word moves toward cell zero
	always_comb begin
		if (hit) begin
			chain_d.hit  = 1'b1;
			chain_d.data = (ctrl.op == polu_pkg::CELL_GET) ? slot_q : idx_p1[7:0];
		end else begin
			chain_d = chain_in;
		end
	end

	always_ff @(posedge clk) begin
		slot_q  <= slot_d;
		chain_q <= chain_d;
	end

	assign slot      = slot_q;
	assign chain_out = chain_q;

endmodule

// ===== tb/positional_ordered_list_unit_tb.sv =====
// testbench for the positional ordered list unit: directed and random requests with a shadow list
module positional_ordered_list_unit_tb;

	localparam int CAPACITY = 128;

	// spare action codes, answered with an error
	localparam logic [2:0] ACT_RSVD5 = 3'd5;
	localparam logic [2:0] ACT_RSVD6 = 3'd6;
	localparam logic [2:0] ACT_RSVD7 = 3'd7;

	// marker byte kept unique in the full list test
	localparam logic [7:0] TAIL_MARK = 8'hEE;

	logic                       clk;
	logic                       arst_n;
	logic                       s_tvalid;
	logic                       s_tready;
	logic [polu_pkg::IN_W-1:0]  s_tdata;
	logic                       m_tvalid;
	logic                       m_tready;
	logic [polu_pkg::OUT_W-1:0] m_tdata;

	// shadow copy of the list contents and length
	logic [7:0] list_slots [CAPACITY];
	int         list_len;

	// answers still owed by the unit, oldest first
	polu_pkg::result_t list_answers [$];
	int                mismatch_count;
	bit                sender_steady;

	positional_ordered_list_unit #(
		.CAPACITY(CAPACITY)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	// clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// apply one request to the shadow list and return the answer it should give
	function automatic polu_pkg::result_t apply_list_op(logic [2:0] act, logic [7:0] pos,
		logic [7:0] val);
		polu_pkg::result_t ans;
		int                p;
		int                j;
		ans = '0;
		p = int'(pos);
		case (act)
			polu_pkg::ACT_INSERT: begin
				if (p < 1 || p > list_len + 1 || list_len >= CAPACITY) begin
					ans.status = 1'b1;
				end else begin
					for (j = list_len; j >= p; j--)
						list_slots[j] = list_slots[j - 1];
					list_slots[p - 1] = val;
					list_len++;
				end
			end
			polu_pkg::ACT_DELETE: begin
				if (p < 1 || p > list_len) begin
					ans.status = 1'b1;
				end else begin
					for (j = p; j < list_len; j++)
						list_slots[j - 1] = list_slots[j];
					list_len--;
				end
			end
			polu_pkg::ACT_GET: begin
				if (p < 1 || p > list_len)
					ans.status = 1'b1;
				else
					ans.read_value = list_slots[p - 1];
			end
			polu_pkg::ACT_LOCATE: begin
				for (j = 0; j < list_len; j++) begin
					if (list_slots[j] == val && ans.found_position == 0)
						ans.found_position = 8'(j + 1);
				end
			end
			polu_pkg::ACT_CLEAR: begin
				list_len = 0;
			end
			default: begin
				ans.status = 1'b1;
			end
		endcase
		ans.count = list_len[7:0];
		ans.empty_res = (list_len == 0);
		return ans;
	endfunction

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap(bit steady);
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// drive one request word and wait for it to be taken
	task automatic send_request(logic [2:0] act, logic [7:0] pos, logic [7:0] val);
		int gap;
		gap = pick_gap(sender_steady);
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tdata = {5'b0, val, pos, act};
		do @(posedge clk); while (!s_tready);
		list_answers.push_back(apply_list_op(act, pos, val));
	endtask

	// hold off the sender until every owed answer is back
	task automatic drain_answers();
		@(negedge clk);
		s_tvalid = 1'b0;
		wait (list_answers.size() == 0);
	endtask

	// every action and the edge cases on a short list
	task automatic test_directed_ops();
		send_request(polu_pkg::ACT_GET, 8'd1, 8'h00);
		send_request(polu_pkg::ACT_DELETE, 8'd1, 8'h00);
		send_request(polu_pkg::ACT_LOCATE, 8'd0, 8'h00);
		send_request(polu_pkg::ACT_INSERT, 8'd0, 8'h11);
		send_request(polu_pkg::ACT_INSERT, 8'd2, 8'h22);
		send_request(polu_pkg::ACT_INSERT, 8'd1, 8'h00);
		send_request(polu_pkg::ACT_INSERT, 8'd1, 8'hFF);
		send_request(polu_pkg::ACT_INSERT, 8'd3, 8'hA5);
		send_request(polu_pkg::ACT_INSERT, 8'd2, 8'h5A);
		send_request(polu_pkg::ACT_GET, 8'd1, 8'hFF);
		send_request(polu_pkg::ACT_GET, 8'd2, 8'h00);
		send_request(polu_pkg::ACT_GET, 8'd4, 8'h00);
		send_request(polu_pkg::ACT_GET, 8'd5, 8'h00);
		send_request(polu_pkg::ACT_GET, 8'd255, 8'hFF);
		send_request(polu_pkg::ACT_LOCATE, 8'd255, 8'hFF);
		send_request(polu_pkg::ACT_LOCATE, 8'd0, 8'h33);
		send_request(polu_pkg::ACT_DELETE, 8'd2, 8'h00);
		send_request(polu_pkg::ACT_DELETE, 8'd0, 8'h00);
		send_request(polu_pkg::ACT_DELETE, 8'd255, 8'hFF);
		send_request(ACT_RSVD5, 8'd1, 8'h00);
		send_request(ACT_RSVD6, 8'd255, 8'hFF);
		send_request(ACT_RSVD7, 8'd2, 8'h5A);
		send_request(polu_pkg::ACT_CLEAR, 8'd255, 8'hFF);
		send_request(polu_pkg::ACT_CLEAR, 8'd0, 8'h00);
		send_request(polu_pkg::ACT_INSERT, 8'd255, 8'hFF);
	endtask

	// fill to capacity, push past it, shrink from both ends, refill both ends, then clear
	task automatic test_full_list();
		logic [7:0] val;
		send_request(polu_pkg::ACT_CLEAR, 8'd0, 8'h00);
		while (list_len < CAPACITY - 1) begin
			do val = 8'($urandom_range(0, 255)); while (val == TAIL_MARK);
			send_request(polu_pkg::ACT_INSERT, 8'($urandom_range(1, list_len + 1)), val);
		end
		send_request(polu_pkg::ACT_INSERT, 8'(CAPACITY), TAIL_MARK);
		send_request(polu_pkg::ACT_INSERT, 8'(CAPACITY + 1), 8'h01);
		send_request(polu_pkg::ACT_INSERT, 8'd1, 8'h02);
		send_request(polu_pkg::ACT_INSERT, 8'd0, 8'h03);
		send_request(polu_pkg::ACT_GET, 8'(CAPACITY), 8'h00);
		send_request(polu_pkg::ACT_GET, 8'(CAPACITY + 1), 8'h00);
		send_request(polu_pkg::ACT_LOCATE, 8'd0, TAIL_MARK);
		send_request(polu_pkg::ACT_LOCATE, 8'd0, list_slots[0]);
		send_request(polu_pkg::ACT_DELETE, 8'(CAPACITY), 8'h00);
		send_request(polu_pkg::ACT_DELETE, 8'd1, 8'h00);
		send_request(polu_pkg::ACT_INSERT, 8'd1, 8'hC3);
		send_request(polu_pkg::ACT_INSERT, 8'(list_len + 1), 8'h3C);
		send_request(polu_pkg::ACT_GET, 8'(CAPACITY), 8'h00);
		send_request(polu_pkg::ACT_CLEAR, 8'd0, 8'h00);
	endtask

	// one random request, mostly well formed against the current length
	task automatic send_random_request(int grow);
		int         r;
		logic [2:0] act;
		logic [7:0] pos;
		logic [7:0] val;
		r = $urandom_range(0, 99);
		pos = 8'($urandom_range(0, 255));
		val = 8'($urandom_range(0, 255));
		if (r < grow)
			act = polu_pkg::ACT_INSERT;
		else if (r < grow + 18)
			act = polu_pkg::ACT_DELETE;
		else if (r < grow + 34)
			act = polu_pkg::ACT_GET;
		else if (r < grow + 48)
			act = polu_pkg::ACT_LOCATE;
		else if (r < grow + 50)
			act = polu_pkg::ACT_CLEAR;
		else if (r < grow + 53)
			act = 3'($urandom_range(ACT_RSVD5, ACT_RSVD7));
		else
			act = 3'($urandom_range(0, 7));
		if ($urandom_range(0, 99) < 88) begin
			if (act == polu_pkg::ACT_INSERT)
				pos = 8'($urandom_range(1, list_len + 1));
			else if ((act == polu_pkg::ACT_DELETE || act == polu_pkg::ACT_GET) && list_len > 0)
				pos = 8'($urandom_range(1, list_len));
		end
		if (act == polu_pkg::ACT_LOCATE && list_len > 0 && $urandom_range(0, 99) < 70)
			val = list_slots[$urandom_range(0, list_len - 1)];
		send_request(act, pos, val);
	endtask

	// a few words, a full drain, more words, another drain, then one more word
	task automatic test_drain_pause();
		send_request(polu_pkg::ACT_INSERT, 8'd1, 8'h81);
		send_request(polu_pkg::ACT_INSERT, 8'd2, 8'h7E);
		send_request(polu_pkg::ACT_LOCATE, 8'd0, 8'h7E);
		drain_answers();
		send_request(polu_pkg::ACT_GET, 8'd2, 8'h00);
		send_request(polu_pkg::ACT_DELETE, 8'd1, 8'h00);
		drain_answers();
		send_request(polu_pkg::ACT_INSERT, 8'd1, 8'h42);
	endtask

	// long random run with growth phases, steady bursts and drains
	task automatic test_random_traffic();
		int grow;
		grow = 40;
		for (int n = 0; n < 1000; n++) begin
			if (n % 100 == 0) begin
				sender_steady = ($urandom_range(0, 3) == 0);
				grow = ($urandom_range(0, 2) == 0) ? 55 : 40;
			end
			if (n % 250 == 249)
				drain_answers();
			send_random_request(grow);
		end
		sender_steady = 1'b0;
	endtask

	// receiver stalls, with long stretches of steady ready
	initial begin : drive_ready
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 9) == 0) begin
				m_tready = 1'b1;
				repeat ($urandom_range(50, 200)) @(negedge clk);
			end else begin
				stall = pick_gap(1'b0);
				if (stall > 0) begin
					m_tready = 1'b0;
					repeat (stall) @(negedge clk);
				end
				m_tready = 1'b1;
				repeat ($urandom_range(1, 4)) @(negedge clk);
			end
		end
	end

	// compare each answer word with the oldest owed answer
	always @(posedge clk) begin : check_answers
		polu_pkg::result_t got;
		polu_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = polu_pkg::result_t'(m_tdata[$bits(polu_pkg::result_t)-1:0]);
			if (list_answers.size() == 0) begin
				$error("answer word with nothing owed: %h", m_tdata);
				mismatch_count++;
			end else begin
				want = list_answers.pop_front();
				if (got.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, got.status);
					mismatch_count++;
				end
				if (got.read_value !== want.read_value) begin
					$error("read_value: expected %0d, got %0d", want.read_value, got.read_value);
					mismatch_count++;
				end
				if (got.found_position !== want.found_position) begin
					$error("found_position: expected %0d, got %0d",
						want.found_position, got.found_position);
					mismatch_count++;
				end
				if (got.count !== want.count) begin
					$error("count: expected %0d, got %0d", want.count, got.count);
					mismatch_count++;
				end
				if (got.empty_res !== want.empty_res) begin
					$error("empty_res: expected %0d, got %0d", want.empty_res, got.empty_res);
					mismatch_count++;
				end
			end
		end
	end

	// overall time limit
	initial begin
		#20_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// reset, tests, drain and verdict
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		list_len = 0;
		mismatch_count = 0;
		sender_steady = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		test_directed_ops();
		test_full_list();
		test_drain_pause();
		test_random_traffic();

		@(negedge clk);
		s_tvalid = 1'b0;
		wait (list_answers.size() == 0);
		repeat (CAPACITY + 8) @(posedge clk);
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
